>>> sv/sap_pkg.sv
package sap_pkg;

  localparam int PHASE_BITS = 24;
  localparam int REG_BITS = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int SINE_BITS = 15;
  localparam int COEF_BITS = 16;
  localparam int COEF_BASE = 16384;
  localparam int COEF_SPREAD = 9830;

  localparam logic [REG_BITS-1:0] UNITY_Q15 = 16'd32768;

  localparam logic [REG_BITS-1:0]        PHASE_STEP_RESET    = 16'd175;
  localparam logic [REG_BITS-1:0]        MOD_DEPTH_RESET     = 16'd16384;
  localparam logic signed [REG_BITS-1:0] FEEDBACK_GAIN_RESET = 16'sd9830;
  localparam logic [REG_BITS-1:0]        WET_MIX_RESET       = 16'd16384;

  // Odd Taylor coefficients of sin(pi/2 * t), t in Q30.
  localparam longint POLY_Q30 [5] = '{
    64'sd1686629713, -64'sd693598368, 64'sd85569739, -64'sd5026947, 64'sd172272
  };

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP    = 8'd0,
    REG_MOD_DEPTH     = 8'd1,
    REG_FEEDBACK_GAIN = 8'd2,
    REG_WET_MIX       = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COEF,
    ST_LANE,
    ST_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ADDR,
    CS_MULT,
    CS_STORE
  } coef_step_e;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_FB,
    LS_FB_ADD,
    LS_STG,
    LS_STG_ADD,
    LS_MIX_WET,
    LS_MIX_DRY,
    LS_MIX_SUM
  } lane_step_e;

  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
  } unit_stat_t;

  function automatic logic [SINE_BITS-1:0] quarter_sine(input int k, input int table_bits);
    longint t;
    longint t2;
    longint p;
    longint s;
    t = longint'(k) <<< (30 - table_bits);
    t2 = (t * t) >>> 30;
    p = POLY_Q30[4];
    for (int i = 3; i >= 0; i--) begin
      p = POLY_Q30[i] + ((p * t2) >>> 30);
    end
    s = (((p * t) >>> 30) + 64'sd16384) >>> 15;
    if (s > 64'sd32767) s = 64'sd32767;
    if (s < 64'sd0) s = 64'sd0;
    return s[SINE_BITS-1:0];
  endfunction

endpackage

>>> sv/sap_if.sv
interface sap_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface sap_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_result;
  logic signed [SAMPLE_BITS-1:0] right_result;

  modport source (output valid, left_result, right_result, input ready);
  modport sink (input valid, left_result, right_result, output ready);
endinterface

interface sap_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [sap_pkg::CFG_INDEX_BITS-1:0]    index;
  logic [sap_pkg::REG_BITS-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sap_coef.sv
module sap_coef #(
  parameter int STAGES = 4,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sap_pkg::unit_ctrl_t                    ctrl_i,
  output sap_pkg::unit_stat_t                    stat_o,
  input  logic [sap_pkg::PHASE_BITS-1:0]         phase_i,
  input  logic [sap_pkg::REG_BITS-1:0]           depth_i,
  output logic signed [sap_pkg::COEF_BITS-1:0]  coef_o [STAGES]
);

  localparam int PhaseBits = sap_pkg::PHASE_BITS;
  localparam int StgW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int IdxW = SINE_TABLE_BITS + 2;
  localparam int AddrW = SINE_TABLE_BITS + 1;
  localparam int Entries = (1 << SINE_TABLE_BITS) + 1;
  localparam int DscW = sap_pkg::REG_BITS + 14;
  localparam int ProdW = DscW + 1 + sap_pkg::REG_BITS;
  localparam logic [13:0] Spread = 14'(sap_pkg::COEF_SPREAD);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(64'sd1 <<< 29);
  localparam logic signed [ProdW-1:0] CoefBase = ProdW'(sap_pkg::COEF_BASE);

  typedef logic [sap_pkg::SINE_BITS-1:0] rom_t [Entries];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < Entries; k++) begin
      r[k] = sap_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [PhaseBits-1:0] offs [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_off
    localparam longint OffFull = (longint'(g) <<< PhaseBits) / STAGES;
    assign offs[g] = OffFull[PhaseBits-1:0];
  end

  sap_pkg::coef_step_e                 step_q, step_d;
  logic [StgW-1:0]                     st_q;
  logic [DscW-1:0]                     dscale_q;
  logic [sap_pkg::SINE_BITS-1:0]       rom_q;
  logic                                neg_q;
  logic signed [ProdW-1:0]             prod_q;
  logic signed [sap_pkg::COEF_BITS-1:0] coef_q [STAGES];

  logic [PhaseBits-1:0]                phase_sum;
  logic [IdxW-1:0]                     idx;
  logic [1:0]                          quad;
  logic [SINE_TABLE_BITS-1:0]          k_low;
  logic [AddrW-1:0]                    addr;
  logic signed [sap_pkg::SINE_BITS:0]  sine;
  logic signed [ProdW-1:0]             coef_wide;
  logic                                done;

  assign phase_sum = phase_i + offs[st_q];
  assign idx = phase_sum[PhaseBits-1 -: IdxW];
  assign quad = idx[IdxW-1 -: 2];
  assign k_low = idx[SINE_TABLE_BITS-1:0];
  assign addr = quad[0] ? ({1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, k_low}) : {1'b0, k_low};
  assign sine = neg_q ? -signed'({1'b0, rom_q}) : signed'({1'b0, rom_q});
  assign coef_wide = ((prod_q + RoundHalf) >>> 30) + CoefBase;

  always_comb begin
    step_d = step_q;
    done = 1'b0;
    case (step_q)
      sap_pkg::CS_IDLE: begin
        if (ctrl_i.start) step_d = sap_pkg::CS_ADDR;
      end
      sap_pkg::CS_ADDR: step_d = sap_pkg::CS_MULT;
      sap_pkg::CS_MULT: step_d = sap_pkg::CS_STORE;
      sap_pkg::CS_STORE: begin
        if (st_q == StgW'(STAGES - 1)) begin
          done = 1'b1;
          step_d = sap_pkg::CS_IDLE;
        end else begin
          step_d = sap_pkg::CS_ADDR;
        end
      end
      default: step_d = sap_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sap_pkg::CS_IDLE;
      st_q <= '0;
    end else begin
      step_q <= step_d;
      if (step_q == sap_pkg::CS_IDLE) begin
        st_q <= '0;
      end else if (step_q == sap_pkg::CS_STORE) begin
        st_q <= st_q + StgW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dscale_q <= DscW'(depth_i * Spread);
    end
    case (step_q)
      sap_pkg::CS_ADDR: begin
        rom_q <= SineRom[addr];
        neg_q <= quad[1];
      end
      sap_pkg::CS_MULT: prod_q <= signed'({1'b0, dscale_q}) * sine;
      sap_pkg::CS_STORE: coef_q[st_q] <= coef_wide[sap_pkg::COEF_BITS-1:0];
      default: ;
    endcase
  end

  assign coef_o = coef_q;
  assign stat_o.done = done;

endmodule

>>> sv/sap_lane.sv
module sap_lane #(
  parameter int STAGES = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sap_pkg::unit_ctrl_t                   ctrl_i,
  output sap_pkg::unit_stat_t                   stat_o,
  input  logic signed [sap_pkg::REG_BITS-1:0]   gain_i,
  input  logic [sap_pkg::REG_BITS-1:0]          mix_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic signed [sap_pkg::COEF_BITS-1:0]  coef_i [STAGES],
  output logic signed [SAMPLE_BITS-1:0]         result_o
);

  localparam int StgW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int AW = SAMPLE_BITS + 1;
  localparam int BW = sap_pkg::REG_BITS + 2;
  localparam int PW = AW + BW;
  localparam int WW = PW + 1;
  localparam logic signed [WW-1:0] SatHi = WW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] SatLo = -SatHi - WW'(1);
  localparam logic signed [WW-1:0] Half = WW'(64'sd16384);

  function automatic logic signed [WW-1:0] rs15(input logic signed [WW-1:0] v);
    return (v + Half) >>> 15;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    if (v > SatHi) r = SatHi;
    else if (v < SatLo) r = SatLo;
    else r = v;
    return r[SAMPLE_BITS-1:0];
  endfunction

  sap_pkg::lane_step_e            step_q, step_d;
  logic [StgW-1:0]                st_q;
  logic signed [SAMPLE_BITS-1:0]  prev_in_q [STAGES];
  logic signed [SAMPLE_BITS-1:0]  prev_out_q [STAGES];
  logic signed [SAMPLE_BITS-1:0]  hold_q;
  logic signed [SAMPLE_BITS-1:0]  x_q;
  logic signed [SAMPLE_BITS-1:0]  result_q;
  logic signed [PW-1:0]           prod_q;
  logic signed [PW-1:0]           acc_q;

  logic signed [AW-1:0]           mul_a;
  logic signed [BW-1:0]           mul_b;
  logic signed [PW-1:0]           product;
  logic [sap_pkg::REG_BITS:0]     dry_w;
  logic signed [BW-1:0]           mix_b;
  logic signed [BW-1:0]           dry_b;
  logic signed [SAMPLE_BITS-1:0]  x_fb;
  logic signed [SAMPLE_BITS-1:0]  y_new;
  logic signed [SAMPLE_BITS-1:0]  mix_res;
  logic                           last;
  logic                           done;

  assign dry_w = {1'b0, sap_pkg::UNITY_Q15} - {1'b0, mix_i};
  assign mix_b = BW'(signed'({1'b0, mix_i}));
  assign dry_b = BW'(signed'({1'b0, dry_w}));
  assign product = mul_a * mul_b;
  assign last = (st_q == StgW'(STAGES - 1));

  assign x_fb = sat(WW'(sample_i) + rs15(WW'(prod_q)));
  assign y_new = sat(WW'(prev_in_q[st_q]) + rs15(WW'(prod_q)));
  assign mix_res = sat(rs15(WW'(acc_q) + WW'(prod_q)));

  always_comb begin
    step_d = step_q;
    mul_a = '0;
    mul_b = '0;
    done = 1'b0;
    case (step_q)
      sap_pkg::LS_IDLE: begin
        if (ctrl_i.start) step_d = sap_pkg::LS_FB;
      end
      sap_pkg::LS_FB: begin
        mul_a = AW'(hold_q);
        mul_b = BW'(gain_i);
        step_d = sap_pkg::LS_FB_ADD;
      end
      sap_pkg::LS_FB_ADD: step_d = sap_pkg::LS_STG;
      sap_pkg::LS_STG: begin
        mul_a = AW'(prev_out_q[st_q]) - AW'(x_q);
        mul_b = BW'(coef_i[st_q]);
        step_d = sap_pkg::LS_STG_ADD;
      end
      sap_pkg::LS_STG_ADD: begin
        step_d = last ? sap_pkg::LS_MIX_WET : sap_pkg::LS_STG;
      end
      sap_pkg::LS_MIX_WET: begin
        mul_a = AW'(x_q);
        mul_b = mix_b;
        step_d = sap_pkg::LS_MIX_DRY;
      end
      sap_pkg::LS_MIX_DRY: begin
        mul_a = AW'(sample_i);
        mul_b = dry_b;
        step_d = sap_pkg::LS_MIX_SUM;
      end
      sap_pkg::LS_MIX_SUM: begin
        done = 1'b1;
        step_d = sap_pkg::LS_IDLE;
      end
      default: step_d = sap_pkg::LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sap_pkg::LS_IDLE;
      st_q <= '0;
      hold_q <= '0;
      for (int i = 0; i < STAGES; i++) begin
        prev_in_q[i] <= '0;
        prev_out_q[i] <= '0;
      end
    end else begin
      step_q <= step_d;
      case (step_q)
        sap_pkg::LS_FB_ADD: st_q <= '0;
        sap_pkg::LS_STG_ADD: begin
          prev_in_q[st_q] <= x_q;
          prev_out_q[st_q] <= y_new;
          st_q <= st_q + StgW'(1);
        end
        sap_pkg::LS_MIX_WET: hold_q <= x_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= product;
    case (step_q)
      sap_pkg::LS_FB_ADD: x_q <= x_fb;
      sap_pkg::LS_STG_ADD: x_q <= y_new;
      sap_pkg::LS_MIX_DRY: acc_q <= prod_q;
      sap_pkg::LS_MIX_SUM: result_q <= mix_res;
      default: ;
    endcase
  end

  assign result_o = result_q;
  assign stat_o.done = done;

endmodule

>>> sv/sap_merge.sv
module sap_merge #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sap_pkg::unit_ctrl_t           ctrl_i,
  output logic                          free_o,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  sap_out_if.source                     out_if
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.start) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      left_q <= left_i;
      right_q <= right_i;
    end
  end

  assign free_o = !valid_q || out_if.ready;
  assign out_if.valid = valid_q;
  assign out_if.left_result = left_q;
  assign out_if.right_result = right_q;

endmodule

>>> sv/stereo_allpass_phaser_core.sv
// Stereo allpass phaser: each input transaction carries one left/right pair of Q1.23 samples
// and yields one output transaction with the mixed pair. An item first has its STAGES allpass
// coefficients formed from the shared sine LFO, stage by stage through the coefficient unit
// (address, multiply, store), then both channels run at once in two lanes, each with one
// multiplier used for the feedback, each allpass stage and the wet/dry mix in turn. A new pair is
// accepted while the previous result is still waiting in the output register. Configuration
// writes are always accepted and update the registers straight away, so a write made during
// an item can change that item's result.
module stereo_allpass_phaser_core #(
  parameter int STAGES = 4,
  parameter int SAMPLE_BITS = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sap_in_if.sink    in_if,
  sap_out_if.source out_if,
  sap_cfg_if.sink   cfg_if
);

  localparam int PhaseBits = sap_pkg::PHASE_BITS;

  sap_pkg::seq_state_e                  state_q, state_d;
  logic [sap_pkg::REG_BITS-1:0]         phase_step_q;
  logic [sap_pkg::REG_BITS-1:0]         mod_depth_q;
  logic signed [sap_pkg::REG_BITS-1:0]  feedback_gain_q;
  logic [sap_pkg::REG_BITS-1:0]         wet_mix_q;
  logic [PhaseBits-1:0]                 lfo_phase_q;
  logic signed [SAMPLE_BITS-1:0]        dry_left_q;
  logic signed [SAMPLE_BITS-1:0]        dry_right_q;

  logic [sap_pkg::REG_BITS-1:0]         depth_c;
  logic [sap_pkg::REG_BITS-1:0]         mix_c;
  logic signed [sap_pkg::COEF_BITS-1:0] coef [STAGES];
  logic signed [SAMPLE_BITS-1:0]        left_res;
  logic signed [SAMPLE_BITS-1:0]        right_res;
  sap_pkg::unit_ctrl_t                  coef_ctrl;
  sap_pkg::unit_stat_t                  coef_stat;
  sap_pkg::unit_ctrl_t                  lane_ctrl;
  sap_pkg::unit_stat_t                  left_stat;
  sap_pkg::unit_stat_t                  right_stat;
  sap_pkg::unit_ctrl_t                  merge_ctrl;
  logic                                 merge_free;
  logic                                 in_ready;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready = in_ready;

  assign depth_c = (mod_depth_q > sap_pkg::UNITY_Q15) ? sap_pkg::UNITY_Q15 : mod_depth_q;
  assign mix_c = (wet_mix_q > sap_pkg::UNITY_Q15) ? sap_pkg::UNITY_Q15 : wet_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= sap_pkg::PHASE_STEP_RESET;
      mod_depth_q <= sap_pkg::MOD_DEPTH_RESET;
      feedback_gain_q <= sap_pkg::FEEDBACK_GAIN_RESET;
      wet_mix_q <= sap_pkg::WET_MIX_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        sap_pkg::REG_PHASE_STEP: phase_step_q <= cfg_if.data;
        sap_pkg::REG_MOD_DEPTH: mod_depth_q <= cfg_if.data;
        sap_pkg::REG_FEEDBACK_GAIN: feedback_gain_q <= signed'(cfg_if.data);
        sap_pkg::REG_WET_MIX: wet_mix_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    in_ready = 1'b0;
    coef_ctrl.start = 1'b0;
    lane_ctrl.start = 1'b0;
    merge_ctrl.start = 1'b0;
    case (state_q)
      sap_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          coef_ctrl.start = 1'b1;
          state_d = sap_pkg::ST_COEF;
        end
      end
      sap_pkg::ST_COEF: begin
        if (coef_stat.done) begin
          lane_ctrl.start = 1'b1;
          state_d = sap_pkg::ST_LANE;
        end
      end
      sap_pkg::ST_LANE: begin
        if (left_stat.done && right_stat.done) state_d = sap_pkg::ST_DONE;
      end
      sap_pkg::ST_DONE: begin
        if (merge_free) begin
          merge_ctrl.start = 1'b1;
          state_d = sap_pkg::ST_IDLE;
        end
      end
      default: state_d = sap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sap_pkg::ST_IDLE;
      lfo_phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (merge_ctrl.start) begin
        lfo_phase_q <= lfo_phase_q + PhaseBits'(phase_step_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_if.valid) begin
      dry_left_q <= in_if.left_sample;
      dry_right_q <= in_if.right_sample;
    end
  end

  sap_coef #(
    .STAGES(STAGES),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_coef (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(coef_ctrl),
    .stat_o(coef_stat),
    .phase_i(lfo_phase_q),
    .depth_i(depth_c),
    .coef_o(coef)
  );

  sap_lane #(
    .STAGES(STAGES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_left (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .stat_o(left_stat),
    .gain_i(feedback_gain_q),
    .mix_i(mix_c),
    .sample_i(dry_left_q),
    .coef_i(coef),
    .result_o(left_res)
  );

  sap_lane #(
    .STAGES(STAGES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_right (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .stat_o(right_stat),
    .gain_i(feedback_gain_q),
    .mix_i(mix_c),
    .sample_i(dry_right_q),
    .coef_i(coef),
    .result_o(right_res)
  );

  sap_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(merge_ctrl),
    .free_o(merge_free),
    .left_i(left_res),
    .right_i(right_res),
    .out_if(out_if)
  );

endmodule

>>> sv/sap_checker.sv
module sap_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] left_result_i,
  input logic [SAMPLE_BITS-1:0] right_result_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(left_result_i) && $stable(right_result_i))
    else $error("output payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted again while an item is in progress");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in progress");

endmodule

bind stereo_allpass_phaser_core sap_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sap_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_if.valid),
  .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .left_result_i(out_if.left_result),
  .right_result_i(out_if.right_result)
);
